### sv/pfm_pkg.sv
`timescale 1ns / 1ps

package pfm_pkg;

  // default sizes
  localparam int PAT_MAX_DEF  = 32;
  localparam int TEXT_MAX_DEF = 65536;

  // width of the pattern_length register
  localparam int CFG_W = 6;

  // item function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TEXT = 1'b1;

  // one input item
  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
    logic [4:0] pattern_index;
    logic       last;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic        found;
    logic [15:0] match_offset;
  } out_item_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic       shift;
    logic       clear;
    logic       rotate;
    logic       load;
    logic [7:0] load_byte;
  } cell_ctrl_t;

endpackage

### sv/pfm_cell.sv
`timescale 1ns / 1ps

module pfm_cell import pfm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  logic       load_sel,
  input  logic [7:0] win_in,
  input  logic [7:0] pat_in,
  output logic [7:0] win_out,
  output logic [7:0] pat_out,
  output logic       hit
);

  logic [7:0] win_r;
  logic [7:0] pat_r;
  logic       hit_r;

  // text window byte, shifted in from the neighbor, cleared after a last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (ctrl.shift) begin
      win_r <= ctrl.clear ? 8'h00 : win_in;
    end
  end

  // byte compare against the incoming window byte, captured per text transaction
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      hit_r <= (win_in == pat_r);
    end
  end

  // pattern byte: loaded when selected, or passed around the ring on realign
  always_ff @(posedge clk) begin
    if (ctrl.rotate) begin
      pat_r <= pat_in;
    end else if (ctrl.load && load_sel) begin
      pat_r <= ctrl.load_byte;
    end
  end

  assign win_out = win_r;
  assign pat_out = pat_r;
  assign hit     = hit_r;

endmodule

### sv/pfm_chain.sv
`timescale 1ns / 1ps

module pfm_chain import pfm_pkg::*; #(
  parameter int PAT_MAX = PAT_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cell_ctrl_t         ctrl,
  input  logic [PAT_MAX-1:0] load_sel,
  input  logic [7:0]         text_byte,
  output logic [PAT_MAX-1:0] hits
);

  logic [7:0] win_q [PAT_MAX];
  logic [7:0] pat_q [PAT_MAX];

  // window flows from cell 0 upward, pattern bytes circulate as a ring
  for (genvar j = 0; j < PAT_MAX; j++) begin : g_cell
    logic [7:0] win_src;
    if (j == 0) begin : g_head
      assign win_src = text_byte;
    end else begin : g_body
      assign win_src = win_q[j-1];
    end

    pfm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .load_sel (load_sel[j]),
      .win_in   (win_src),
      .pat_in   (pat_q[(j + PAT_MAX - 1) % PAT_MAX]),
      .win_out  (win_q[j]),
      .pat_out  (pat_q[j]),
      .hit      (hits[j])
    );
  end

endmodule

### sv/first_pattern_match_finder_top.sv
`timescale 1ns / 1ps

// First-match byte pattern finder.
// Input channel (in_valid/in_stall/in_data): func = load writes data_byte to
// pattern position pattern_index; func = text streams one text byte, and the
// byte with last set closes the text. Only a closing text byte gives a result.
// Result channel (out_valid/out_stall/out_data): found and the start offset of
// the leftmost match (0 when none). Config channel (cfg_valid/cfg_ready/
// cfg_data) writes pattern_length; write it only while the block is idle.
// Throughput: one transaction per cycle while in_stall is low. A result is
// registered after its closing byte is accepted: compare captured in the cells,
// then the result register. After a length write the pattern ring rotates one
// position per cycle until it is aligned to the new length, with in_stall high.
// Reset: window and counters cleared, pattern_length = 1; pattern bytes are
// undefined until loaded. While out_stall holds a result, input keeps flowing
// until a second closing byte reaches the match stage, which then waits and
// raises in_stall.
module first_pattern_match_finder_top import pfm_pkg::*; #(
  parameter int PAT_MAX  = PAT_MAX_DEF,
  parameter int TEXT_MAX = TEXT_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int IW  = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
  localparam int LW  = $clog2(PAT_MAX + 1);
  localparam int EW  = (LW > CFG_W) ? LW : CFG_W;
  localparam int AW  = LW + 1;
  localparam int CW  = $clog2(TEXT_MAX);
  localparam int OW  = (CW > 16) ? CW : 16;

  // clip a length value to the store depth
  function automatic logic [LW-1:0] clip_len(input logic [CFG_W-1:0] v);
    logic [EW-1:0] ve;
    ve = EW'(v);
    if (ve > EW'(PAT_MAX)) begin
      ve = EW'(PAT_MAX);
    end
    return ve[LW-1:0];
  endfunction

  logic [CFG_W-1:0] pattern_length_r;
  logic [IW-1:0]    align_r, align_nxt;
  logic [IW-1:0]    target_r, target_nxt;
  logic [LW-1:0]    eff_len, cfg_eff, cfg_eff_m1;
  logic             rotating;

  logic [CW-1:0]    bytes_seen_r;
  logic             s1_v_r, s1_last_r;
  logic [CW-1:0]    s1_cnt_r;
  logic             s1_go;
  logic             match_seen_r, match_seen_nxt;
  logic [CW-1:0]    first_offset_r, first_offset_nxt;
  logic             out_valid_r;
  out_item_t        out_data_r, out_data_nxt;

  logic             in_acc, text_acc, load_ok;
  logic [AW-1:0]    idx_e, align_e, tgt_e;
  logic [PAT_MAX-1:0] load_sel, hits, hit_ok;
  cell_ctrl_t       ctrl;

  logic [CW:0]      cnt1, len_c, offs;
  logic             all_hit, new_match;
  logic [OW-1:0]    offs_ext;

  // length register and ring alignment target
  assign cfg_ready  = 1'b1;
  assign eff_len    = clip_len(pattern_length_r);
  assign cfg_eff    = clip_len(cfg_data);
  assign cfg_eff_m1 = cfg_eff - 1'b1;
  assign target_nxt = (cfg_eff == '0) ? '0 : cfg_eff_m1[IW-1:0];
  assign rotating   = (align_r != target_r);
  assign align_nxt  = (align_r == IW'(PAT_MAX - 1)) ? '0 : align_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_length_r <= CFG_W'(1);
      target_r         <= '0;
      align_r          <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        pattern_length_r <= cfg_data;
        target_r         <= target_nxt;
      end
      if (rotating) begin
        align_r <= align_nxt;
      end
    end
  end

  // input handshake
  assign s1_go    = !(s1_v_r && s1_last_r && out_valid_r && out_stall);
  assign in_stall = rotating || !s1_go;
  assign in_acc   = in_valid && !in_stall;
  assign text_acc = in_acc && (in_data.func == FUNC_TEXT);

  // pattern load: cell holding pattern[idx] is (align - idx) mod PAT_MAX
  assign idx_e   = AW'(in_data.pattern_index);
  assign align_e = AW'(align_r);
  assign load_ok = (idx_e < AW'(PAT_MAX));
  assign tgt_e   = (align_e >= idx_e) ? (align_e - idx_e)
                                      : (align_e + AW'(PAT_MAX) - idx_e);

  always_comb begin
    for (int j = 0; j < PAT_MAX; j++) begin
      load_sel[j] = (tgt_e == AW'(j));
    end
  end

  assign ctrl.shift     = text_acc;
  assign ctrl.clear     = in_data.last;
  assign ctrl.rotate    = rotating;
  assign ctrl.load      = in_acc && (in_data.func == FUNC_LOAD) && load_ok;
  assign ctrl.load_byte = in_data.data_byte;

  pfm_chain #(
    .PAT_MAX (PAT_MAX)
  ) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .load_sel  (load_sel),
    .text_byte (in_data.data_byte),
    .hits      (hits)
  );

  // text byte counter, saturating, cleared after the closing byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r <= '0;
    end else if (text_acc) begin
      if (in_data.last) begin
        bytes_seen_r <= '0;
      end else if (bytes_seen_r < CW'(TEXT_MAX - 1)) begin
        bytes_seen_r <= bytes_seen_r + 1'b1;
      end
    end
  end

  // match stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_go) begin
      s1_v_r <= text_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s1_last_r <= in_data.last;
      s1_cnt_r  <= bytes_seen_r;
    end
  end

  // cells beyond the pattern length always agree
  always_comb begin
    for (int j = 0; j < PAT_MAX; j++) begin
      hit_ok[j] = hits[j] || (LW'(j) >= eff_len);
    end
  end

  assign all_hit   = &hit_ok;
  assign cnt1      = {1'b0, s1_cnt_r} + 1'b1;
  assign len_c     = (CW + 1)'(eff_len);
  assign offs      = cnt1 - len_c;
  assign new_match = s1_v_r && !match_seen_r && (eff_len != '0) && (cnt1 >= len_c)
                     && all_hit;

  assign match_seen_nxt   = match_seen_r || new_match;
  assign first_offset_nxt = new_match ? offs[CW-1:0] : first_offset_r;
  assign offs_ext         = OW'(first_offset_nxt);

  // first match record, cleared once the closing byte has been reported
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_seen_r   <= 1'b0;
      first_offset_r <= '0;
    end else if (s1_go && s1_v_r) begin
      if (s1_last_r) begin
        match_seen_r   <= 1'b0;
        first_offset_r <= '0;
      end else begin
        match_seen_r   <= match_seen_nxt;
        first_offset_r <= first_offset_nxt;
      end
    end
  end

  // result register
  assign out_data_nxt.found        = match_seen_nxt;
  assign out_data_nxt.match_offset = match_seen_nxt ? offs_ext[15:0] : 16'h0000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_v_r && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_v_r && s1_last_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_rotate_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    rotating |-> in_stall)
    else $error("input accepted while pattern ring is realigning");

  a_last_reaches_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (text_acc && in_data.last) |=> (s1_v_r && s1_last_r))
    else $error("closing text byte did not reach match stage");

  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |-> (out_data.match_offset == 16'h0000))
    else $error("nonzero offset on a result without a match");

  a_hold_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_go) |-> in_stall)
    else $error("input accepted while match stage is held");

endmodule
